// ----- hdl/ipbf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipbf_pkg
// Types, codes and constants of the IPv4 address blacklist packet filter.
// ----------------------------------------------------------------------------
package ipbf_pkg;

  // default number of slots in each banned set
  localparam int unsigned TABLE_SLOTS_DEF = 1024;

  // header layout
  localparam logic [5:0] IP_HDR_BYTES  = 6'd20;
  localparam logic [5:0] TCP_END_BYTES = 6'd40;   // IP header plus TCP header
  localparam logic [5:0] UDP_END_BYTES = 6'd28;   // IP header plus UDP header
  localparam logic [5:0] POS_LIMIT     = 6'd40;
  localparam logic [5:0] POS_PROTOCOL  = 6'd9;
  localparam logic [5:0] POS_SRC_LO    = 6'd12;
  localparam logic [5:0] POS_DST_LO    = 6'd16;
  localparam logic [5:0] POS_SPORT_LO  = 6'd20;
  localparam logic [5:0] POS_DPORT_LO  = 6'd22;
  localparam logic [5:0] POS_DPORT_HI  = 6'd24;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // one set entry: valid bit over the address
  localparam int unsigned ENTRY_W = 33;

  // input selector codes
  typedef enum logic [1:0] {
    FUNC_PKT_BYTE = 2'd0,
    FUNC_WR_INGR  = 2'd1,
    FUNC_WR_EGR   = 2'd2,
    FUNC_UNUSED   = 2'd3
  } func_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic        is_ingress;
    logic [9:0]  slot_index;
    logic [31:0] entry_address;
    logic        entry_valid;
  } in_beat_t;

  typedef struct packed {
    logic        pass_packet;
    logic        has_record;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic        banned;
    logic        ingress_flag;
  } out_beat_t;

endpackage
`default_nettype wire

// ----- hdl/ipbf_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipbf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ipbf_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ip_blacklist_packet_filter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ip_blacklist_packet_filter_top
// IPv4 blacklist filter: header capture, banned-set tables, verdict per packet.
// ----------------------------------------------------------------------------
// Packet bytes, table writes and unused-selector beats are taken one per cycle
// while the sequencer is idle. The final byte of a packet with a complete header
// starts a linear search of that direction's set RAM, one slot per cycle through
// its single read port, so the input stalls through the search, drain and done
// states after such a beat; a truncated packet stalls the input in the done state.
// The verdict sits in an output register, so the next packet streams in while the
// result waits. After reset both set RAMs are swept to empty, one slot per cycle,
// before the first beat is taken.
// ----------------------------------------------------------------------------
module ip_blacklist_packet_filter_top #(
  parameter int unsigned TABLE_SLOTS = ipbf_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ipbf_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ipbf_pkg::out_beat_t      out_data
);

  localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [CW-1:0] LAST_SLOT = CW'(TABLE_SLOTS - 1);
  localparam logic [31:0] SLOTS32 = 32'(TABLE_SLOTS);

  ipbf_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd_vld_r;
  logic          hit_r, hit_nxt;

  // packet capture state
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dport_r, dport_nxt;

  // pending result and search key
  ipbf_pkg::out_beat_t res_r, res_nxt;
  logic [31:0]         key_r, key_nxt;
  logic                dir_r, dir_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  ipbf_pkg::out_beat_t out_data_r, out_data_nxt;

  // combinational capture view
  logic [5:0]  c_pos;
  logic [31:0] c_src, c_dst;
  logic [7:0]  c_proto;
  logic [15:0] c_sport, c_dport;
  logic        trunc, ports;

  logic        in_fire, pkt_fire, slot_ok;
  logic [31:0] slot_ext;
  logic [AW-1:0] slot_addr;

  // RAM ports
  logic                          we_ingr, we_egr, ram_re;
  logic [AW-1:0]                 waddr, raddr;
  logic [ipbf_pkg::ENTRY_W-1:0]  wdata, rdata_ingr, rdata_egr, rdata_sel;
  logic                          match;

  assign in_ready  = (state_r == ipbf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_fire  = in_valid && in_ready;
  assign pkt_fire = in_fire && (in_data.func == ipbf_pkg::FUNC_PKT_BYTE);
  assign slot_ext = 32'(in_data.slot_index);
  assign slot_addr = slot_ext[AW-1:0];
  assign slot_ok  = (slot_ext < SLOTS32);

  // RAM port muxing: clearing sweep, table writes, search reads
  always_comb begin
    if (state_r == ipbf_pkg::ST_CLEAR) begin
      we_ingr = 1'b1;
      we_egr  = 1'b1;
      waddr   = cnt_r[AW-1:0];
      wdata   = '0;
    end else begin
      we_ingr = in_fire && slot_ok && (in_data.func == ipbf_pkg::FUNC_WR_INGR);
      we_egr  = in_fire && slot_ok && (in_data.func == ipbf_pkg::FUNC_WR_EGR);
      waddr   = slot_addr;
      wdata   = {in_data.entry_valid, in_data.entry_address};
    end
  end

  assign ram_re = (state_r == ipbf_pkg::ST_SEARCH);
  assign raddr  = cnt_r[AW-1:0];

  ipbf_ram #(
    .WIDTH (ipbf_pkg::ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ingr_ram (
    .clk   (clk),
    .we    (we_ingr),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata_ingr)
  );

  ipbf_ram #(
    .WIDTH (ipbf_pkg::ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_egr_ram (
    .clk   (clk),
    .we    (we_egr),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata_egr)
  );

  // compare the slot read last cycle against the key
  assign rdata_sel = dir_r ? rdata_ingr : rdata_egr;
  assign match = rdata_sel[ipbf_pkg::ENTRY_W-1] && (rdata_sel[31:0] == key_r);

  // header capture for the current byte
  always_comb begin
    c_pos   = pos_r;
    c_src   = src_r;
    c_dst   = dst_r;
    c_proto = proto_r;
    c_sport = sport_r;
    c_dport = dport_r;
    if (pos_r < ipbf_pkg::POS_LIMIT) begin
      c_pos = pos_r + 6'd1;
      if (pos_r == ipbf_pkg::POS_PROTOCOL) begin
        c_proto = in_data.packet_byte;
      end else if (pos_r >= ipbf_pkg::POS_SRC_LO && pos_r < ipbf_pkg::POS_DST_LO) begin
        c_src = {src_r[23:0], in_data.packet_byte};
      end else if (pos_r >= ipbf_pkg::POS_DST_LO && pos_r < ipbf_pkg::POS_SPORT_LO) begin
        c_dst = {dst_r[23:0], in_data.packet_byte};
      end else if (pos_r >= ipbf_pkg::POS_SPORT_LO && pos_r < ipbf_pkg::POS_DPORT_LO) begin
        c_sport = {sport_r[7:0], in_data.packet_byte};
      end else if (pos_r >= ipbf_pkg::POS_DPORT_LO && pos_r < ipbf_pkg::POS_DPORT_HI) begin
        c_dport = {dport_r[7:0], in_data.packet_byte};
      end
    end
  end

  // truncation check on the final length
  always_comb begin
    trunc = (c_pos < ipbf_pkg::IP_HDR_BYTES)
         || ((c_proto == ipbf_pkg::PROTO_TCP) && (c_pos < ipbf_pkg::TCP_END_BYTES))
         || ((c_proto == ipbf_pkg::PROTO_UDP) && (c_pos < ipbf_pkg::UDP_END_BYTES));
    ports = (c_proto == ipbf_pkg::PROTO_TCP) || (c_proto == ipbf_pkg::PROTO_UDP);
  end

  // sequencer, capture update, output register
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    proto_nxt     = proto_r;
    sport_nxt     = sport_r;
    dport_nxt     = dport_r;
    res_nxt       = res_r;
    key_nxt       = key_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (rd_vld_r && match) begin
      hit_nxt = 1'b1;
    end

    case (state_r)
      ipbf_pkg::ST_CLEAR: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_SLOT) begin
          state_nxt = ipbf_pkg::ST_IDLE;
        end
      end
      ipbf_pkg::ST_IDLE: begin
        if (pkt_fire) begin
          if (in_data.last_byte) begin
            // packet end: clear capture; unless truncated, build the record and start the lookup
            pos_nxt   = '0;
            src_nxt   = '0;
            dst_nxt   = '0;
            proto_nxt = '0;
            sport_nxt = '0;
            dport_nxt = '0;
            hit_nxt   = 1'b0;
            cnt_nxt   = '0;
            dir_nxt   = in_data.is_ingress;
            key_nxt   = in_data.is_ingress ? c_src : c_dst;
            res_nxt   = '0;
            res_nxt.pass_packet = 1'b1;
            if (trunc) begin
              state_nxt = ipbf_pkg::ST_DONE;
            end else begin
              res_nxt.has_record   = 1'b1;
              res_nxt.src_address  = c_src;
              res_nxt.dst_address  = c_dst;
              res_nxt.src_port     = ports ? c_sport : 16'd0;
              res_nxt.dst_port     = ports ? c_dport : 16'd0;
              res_nxt.protocol     = c_proto;
              res_nxt.ingress_flag = in_data.is_ingress;
              state_nxt = ipbf_pkg::ST_SEARCH;
            end
          end else begin
            pos_nxt   = c_pos;
            src_nxt   = c_src;
            dst_nxt   = c_dst;
            proto_nxt = c_proto;
            sport_nxt = c_sport;
            dport_nxt = c_dport;
          end
        end
      end
      ipbf_pkg::ST_SEARCH: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_SLOT) begin
          state_nxt = ipbf_pkg::ST_DRAIN;
        end
      end
      ipbf_pkg::ST_DRAIN: begin
        // last slot compares this cycle
        state_nxt = ipbf_pkg::ST_DONE;
      end
      ipbf_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_data_nxt.banned      = hit_r;
          out_data_nxt.pass_packet = !hit_r;
          state_nxt = ipbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ipbf_pkg::ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipbf_pkg::ST_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      pos_r       <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      proto_r     <= '0;
      sport_r     <= '0;
      dport_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= ram_re;
      hit_r       <= hit_nxt;
      pos_r       <= pos_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      proto_r     <= proto_nxt;
      sport_r     <= sport_nxt;
      dport_r     <= dport_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    key_r      <= key_nxt;
    dir_r      <= dir_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
